FILE: hw/rtl/minimum_image_neighbor_filter_assert.svh
// assertion macros used by the checker file minf_checker.sv
`ifndef MINIMUM_IMAGE_NEIGHBOR_FILTER_ASSERT_SVH
`define MINIMUM_IMAGE_NEIGHBOR_FILTER_ASSERT_SVH

// checked only while out of reset
`define MINF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MINF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/minf_pkg.sv
`timescale 1ns / 1ps
package minf_pkg;

	// fixed field widths
	localparam int BOX_BITS       = 24;
	localparam int MOL_BITS       = 16;
	localparam int DIST_BITS      = 48;
	localparam int CFG_DATA_BITS  = 48;
	localparam int CFG_INDEX_BITS = 3;

	// per-axis magnitudes at or above 2^BIG_SHIFT square to BIG_SQ
	localparam int BIG_SHIFT = 25;
	localparam int SQ_BITS   = 2 * BIG_SHIFT + 1;
	localparam int SUM_BITS  = SQ_BITS + 1;
	localparam logic [SQ_BITS-1:0] BIG_SQ = SQ_BITS'(1) << (2 * BIG_SHIFT);

	localparam logic [BOX_BITS-1:0] BOX_RESET = '1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEST = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BOX_X      = 3'd0,
		REG_BOX_Y      = 3'd1,
		REG_BOX_Z      = 3'd2,
		REG_CUTOFF_SQ  = 3'd3,
		REG_ALLOW_SAME = 3'd4,
		REG_ALLOW_OTHER = 3'd5
	} cfg_reg_t;

	// stage load enables handed to the axis units
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} stage_ctl_t;

endpackage

FILE: hw/rtl/minf_in_if.sv
`timescale 1ns / 1ps
interface minf_in_if #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 16
) ();
	import minf_pkg::*;

	logic                  valid;
	logic                  ready;
	op_t                   op;
	logic [INDEX_BITS-1:0] atom_index;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [COORD_BITS-1:0] pos_z;
	logic [MOL_BITS-1:0]   molecule_id;
	logic                  bond_excluded;
	logic                  candidate_enabled;

	modport source (
		output valid, op, atom_index, pos_x, pos_y, pos_z, molecule_id,
		bond_excluded, candidate_enabled,
		input  ready
	);

	modport sink (
		input  valid, op, atom_index, pos_x, pos_y, pos_z, molecule_id,
		bond_excluded, candidate_enabled,
		output ready
	);
endinterface

FILE: hw/rtl/minf_out_if.sv
`timescale 1ns / 1ps
interface minf_out_if #(
	parameter int INDEX_BITS = 16
) ();
	import minf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] neighbor_index;
	logic [DIST_BITS-1:0]  distance_squared;

	modport source (
		output valid, neighbor_index, distance_squared,
		input  ready
	);

	modport sink (
		input  valid, neighbor_index, distance_squared,
		output ready
	);
endinterface

FILE: hw/rtl/minf_axis.sv
`timescale 1ns / 1ps
module minf_axis #(
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  minf_pkg::stage_ctl_t          ctl,
	input  logic [COORD_BITS-1:0]         cand,
	input  logic [COORD_BITS-1:0]         cent,
	input  logic [minf_pkg::BOX_BITS-1:0] box,
	output logic [minf_pkg::SQ_BITS-1:0]  sq_s3
);
	import minf_pkg::*;

	// wide enough for the doubled difference and for the clamp test
	localparam int AW = (COORD_BITS + 2 > BIG_SHIFT + 1) ? COORD_BITS + 2 : BIG_SHIFT + 1;
	localparam logic [AW-1:0] CoordMask = (AW'(1) << COORD_BITS) - AW'(1);

	logic signed [AW-1:0]      diff;
	logic signed [AW-1:0]      dbl;
	logic signed [AW-1:0]      box_w;
	logic signed [AW-1:0]      wrapped;
	logic signed [AW-1:0]      mag_w;
	logic                      big;
	logic                      big_s2;
	logic [BIG_SHIFT-1:0]      mag_s2;
	logic [2*BIG_SHIFT-1:0]    prod;

	// minimum image wrap, compared as 2*d against the box length
	always_comb begin
		box_w = AW'(box) & CoordMask;
		diff  = AW'(cand) - AW'(cent);
		dbl   = diff <<< 1;
		if (dbl > box_w) begin
			wrapped = diff - box_w;
		end else if (dbl < -box_w) begin
			wrapped = diff + box_w;
		end else begin
			wrapped = diff;
		end
		mag_w = wrapped[AW-1] ? -wrapped : wrapped;
		big   = (mag_w >>> BIG_SHIFT) != '0;
	end

	// magnitude stage
	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			big_s2 <= big;
			mag_s2 <= mag_w[BIG_SHIFT-1:0];
		end
	end

	assign prod = mag_s2 * mag_s2;

	// square stage, clamped magnitudes count as the big square
	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			sq_s3 <= big_s2 ? BIG_SQ : SQ_BITS'(prod);
		end
	end
endmodule

FILE: hw/rtl/minimum_image_neighbor_filter.sv
`timescale 1ns / 1ps
// Minimum image neighbor filter for a periodic orthorhombic box.
// Channel item (sink): op OP_LOAD stores the center atom (index, position,
// molecule) and gives no result; op OP_TEST tests a candidate against the
// center. Channel result (source): one word per candidate that is enabled,
// not bonded, not the center, allowed by the molecule rule and within the
// squared cutoff, carrying its index and the wrapped squared distance.
// Configuration: cfg_we/cfg_index/cfg_data write box lengths, cutoff and the
// molecule rule; write only while the block is idle.
// A result word shows on result.valid once its item has passed the input
// register, the wrap/clamp stage, the square stage and the sum and compare
// into the output register. Throughput: one item per cycle while results are
// taken; each stage moves when the one after it is empty or moving, so the
// three 25 x 25 squarers and the sum/compare set the clock.
// A stalled receiver holds the output word; items keep entering until every
// stage is full, then item.ready falls.
// Reset (arst_n low) empties the pipeline, sets the center to index 0 at the
// origin in molecule 0 and loads the register reset values.
module minimum_image_neighbor_filter #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [minf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [minf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	minf_in_if.sink                             item,
	minf_out_if.source                          result
);
	import minf_pkg::*;

	// configuration registers
	logic [BOX_BITS-1:0]   box_x_q;
	logic [BOX_BITS-1:0]   box_y_q;
	logic [BOX_BITS-1:0]   box_z_q;
	logic [DIST_BITS-1:0]  cutoff_q;
	logic                  allow_same_q;
	logic                  allow_other_q;

	// center atom
	logic [INDEX_BITS-1:0] center_idx_q;
	logic [COORD_BITS-1:0] center_x_q;
	logic [COORD_BITS-1:0] center_y_q;
	logic [COORD_BITS-1:0] center_z_q;
	logic [MOL_BITS-1:0]   center_mol_q;

	// input stage
	logic                  v_s1;
	op_t                   op_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [COORD_BITS-1:0] px_s1;
	logic [COORD_BITS-1:0] py_s1;
	logic [COORD_BITS-1:0] pz_s1;
	logic [MOL_BITS-1:0]   mol_s1;
	logic                  bond_s1;
	logic                  enab_s1;

	logic                  v_s2;
	logic [INDEX_BITS-1:0] idx_s2;
	logic                  v_s3;
	logic [INDEX_BITS-1:0] idx_s3;

	// output register
	logic                  out_v_q;
	logic [INDEX_BITS-1:0] out_idx_q;
	logic [DIST_BITS-1:0]  out_dist_q;

	logic                  pass_s1;
	logic                  mol_match;
	logic                  en_o;
	logic                  en3;
	logic                  en2;
	logic                  en1;
	stage_ctl_t            ctl;
	logic [SQ_BITS-1:0]    sq_x_s3;
	logic [SQ_BITS-1:0]    sq_y_s3;
	logic [SQ_BITS-1:0]    sq_z_s3;
	logic [SUM_BITS-1:0]   sum3;
	logic                  hit3;

	// stage advance: a stage moves when the next one is empty or moving
	assign en_o = !out_v_q || result.ready;
	assign en3  = !v_s3 || en_o;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;

	assign item.ready  = en1;
	assign ctl.load_s2 = en2;
	assign ctl.load_s3 = en3;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q       <= BOX_RESET;
			box_y_q       <= BOX_RESET;
			box_z_q       <= BOX_RESET;
			cutoff_q      <= '0;
			allow_same_q  <= 1'b1;
			allow_other_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOX_X:       box_x_q       <= cfg_data[BOX_BITS-1:0];
				REG_BOX_Y:       box_y_q       <= cfg_data[BOX_BITS-1:0];
				REG_BOX_Z:       box_z_q       <= cfg_data[BOX_BITS-1:0];
				REG_CUTOFF_SQ:   cutoff_q      <= cfg_data[DIST_BITS-1:0];
				REG_ALLOW_SAME:  allow_same_q  <= cfg_data[0];
				REG_ALLOW_OTHER: allow_other_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= item.op;
			idx_s1  <= item.atom_index;
			px_s1   <= item.pos_x;
			py_s1   <= item.pos_y;
			pz_s1   <= item.pos_z;
			mol_s1  <= item.molecule_id;
			bond_s1 <= item.bond_excluded;
			enab_s1 <= item.candidate_enabled;
		end
	end

	// center update when a load word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_idx_q <= '0;
			center_x_q   <= '0;
			center_y_q   <= '0;
			center_z_q   <= '0;
			center_mol_q <= '0;
		end else if (v_s1 && en2 && op_s1 == OP_LOAD) begin
			center_idx_q <= idx_s1;
			center_x_q   <= px_s1;
			center_y_q   <= py_s1;
			center_z_q   <= pz_s1;
			center_mol_q <= mol_s1;
		end
	end

	// candidate qualification against the current center
	always_comb begin
		mol_match = mol_s1 == center_mol_q;
		pass_s1  = op_s1 == OP_TEST && enab_s1 && !bond_s1 &&
			idx_s1 != center_idx_q && (mol_match ? allow_same_q : allow_other_q);
	end

	minf_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk   (clk),
		.ctl   (ctl),
		.cand  (px_s1),
		.cent  (center_x_q),
		.box   (box_x_q),
		.sq_s3 (sq_x_s3)
	);

	minf_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk   (clk),
		.ctl   (ctl),
		.cand  (py_s1),
		.cent  (center_y_q),
		.box   (box_y_q),
		.sq_s3 (sq_y_s3)
	);

	minf_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
		.clk   (clk),
		.ctl   (ctl),
		.cand  (pz_s1),
		.cent  (center_z_q),
		.box   (box_z_q),
		.sq_s3 (sq_z_s3)
	);

	// valid bits of the inner stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= v_s1 && pass_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			idx_s2 <= idx_s1;
		end
		if (en3) begin
			idx_s3 <= idx_s2;
		end
	end

	// sum of squares against the cutoff
	assign sum3 = SUM_BITS'(sq_x_s3) + SUM_BITS'(sq_y_s3) + SUM_BITS'(sq_z_s3);
	assign hit3 = sum3 <= SUM_BITS'(cutoff_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_o) begin
			out_v_q <= v_s3 && hit3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			out_idx_q  <= idx_s3;
			out_dist_q <= sum3[DIST_BITS-1:0];
		end
	end

	assign result.valid            = out_v_q;
	assign result.neighbor_index   = out_idx_q;
	assign result.distance_squared = out_dist_q;
endmodule

FILE: hw/rtl/minf_checker.sv
`timescale 1ns / 1ps
`include "minimum_image_neighbor_filter_assert.svh"
module minf_checker #(
	parameter int INDEX_BITS = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [INDEX_BITS-1:0]          neighbor_index,
	input logic [minf_pkg::DIST_BITS-1:0] distance_squared
);
	import minf_pkg::*;

	logic stalled;

	// result offered but not taken
	assign stalled = out_valid && !out_ready;

	property p_out_stable;
		stalled |=> $stable(neighbor_index) && $stable(distance_squared);
	endproperty

	// a stalled result word stays offered
	`MINF_ASSERT(a_out_hold, clk, arst_n, stalled |=> out_valid, "result dropped while stalled")

	// and keeps its payload
	`MINF_ASSERT(a_out_stable, clk, arst_n, p_out_stable, "result changed while stalled")

	// the input only stalls when every stage is full behind a stalled output
	`MINF_ASSERT(a_in_stall, clk, arst_n, !in_ready |-> stalled, "input stall without backpressure")

	// no result is offered while in reset
	`MINF_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "result offered during reset")
endmodule

bind minimum_image_neighbor_filter minf_checker #(.INDEX_BITS(INDEX_BITS)) u_minf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (item.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.neighbor_index   (result.neighbor_index),
	.distance_squared (result.distance_squared)
);
